// ===== src/command_frame_deframer_assert.svh =====
// Assertion macros used by the command frame deframer parser.
`ifndef COMMAND_FRAME_DEFRAMER_ASSERT_SVH
`define COMMAND_FRAME_DEFRAMER_ASSERT_SVH

// Checks an implication on every rising clock edge outside reset.
`define CFD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define CFD_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== src/cfd_pkg.sv =====
// Shared types and constants of the command frame deframer.
package cfd_pkg;

	localparam int NAME_LEN_W  = 8;
	localparam int PARAM_LEN_W = 14;
	localparam int COLLECT_W   = 32;
	localparam int BYTE_W      = 8;
	localparam int ROLE_W      = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = PARAM_LEN_W;

	localparam logic [NAME_LEN_W-1:0]  MAX_NAME_LEN_RST  = NAME_LEN_W'(128);
	localparam logic [PARAM_LEN_W-1:0] MAX_PARAM_LEN_RST = PARAM_LEN_W'(8 * 1024);

	localparam logic [CFG_IDX_W-1:0] REG_MAX_NAME_LEN  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PARAM_LEN = CFG_IDX_W'(1);

	localparam logic [ROLE_W-1:0] ROLE_HEADER  = 2'd0;
	localparam logic [ROLE_W-1:0] ROLE_NAME    = 2'd1;
	localparam logic [ROLE_W-1:0] ROLE_PARAM   = 2'd2;
	localparam logic [ROLE_W-1:0] ROLE_IGNORED = 2'd3;

	typedef struct packed {
		logic [NAME_LEN_W-1:0]  max_name_len;
		logic [PARAM_LEN_W-1:0] max_param_len;
	} cfd_cfg_t;

	typedef struct packed {
		logic [ROLE_W-1:0]      role;
		logic [BYTE_W-1:0]      value;
		logic [NAME_LEN_W-1:0]  name_len;
		logic [COLLECT_W-1:0]   hash;
		logic [PARAM_LEN_W-1:0] param_len;
		logic                   frame_done;
		logic                   error_now;
		logic                   halted;
	} cfd_result_t;

endpackage

// ===== src/cfd_parser.sv =====
// Frame parsing state and per-byte role decision of the command frame deframer.
module cfd_parser
	import cfd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [BYTE_W-1:0]     data_byte,
	input  logic                  link_closed,
	input  cfd_cfg_t              cfg,
	output cfd_result_t           res
);

	typedef enum logic [2:0] {
		PH_NAME_LEN,
		PH_NAME,
		PH_HASH,
		PH_PARAM_LEN,
		PH_PARAM
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [1:0]             idx_q, idx_d;
	logic [COLLECT_W-1:0]   fc_q, fc_d;
	logic [NAME_LEN_W-1:0]  name_len_q, name_len_d;
	logic [COLLECT_W-1:0]   hash_q, hash_d;
	logic [PARAM_LEN_W-1:0] param_len_q, param_len_d;
	logic [PARAM_LEN_W-1:0] rem_q, rem_d;
	logic                   stopped_q, stopped_d;

	logic [COLLECT_W-1:0]   fc_shift;
	logic                   full;
	logic [PARAM_LEN_W-1:0] rem_dec;

	assign fc_shift = {data_byte, fc_q[COLLECT_W-1:BYTE_W]};
	assign full     = (idx_q == 2'd3);
	assign rem_dec  = rem_q - PARAM_LEN_W'(1);

	always_comb begin
		phase_d     = phase_q;
		idx_d       = idx_q;
		fc_d        = fc_q;
		name_len_d  = name_len_q;
		hash_d      = hash_q;
		param_len_d = param_len_q;
		rem_d       = rem_q;
		stopped_d   = stopped_q;
		res.role       = ROLE_IGNORED;
		res.value      = data_byte;
		res.frame_done = 1'b0;
		res.error_now  = 1'b0;
		if (link_closed) begin
			res.value = '0;
			stopped_d = 1'b1;
		end else if (!stopped_q) begin
			unique case (phase_q)
				PH_NAME: begin
					res.role = ROLE_NAME;
					rem_d    = rem_dec;
					if (rem_dec == '0) begin
						phase_d = PH_HASH;
					end
				end
				PH_HASH: begin
					res.role = ROLE_HEADER;
					fc_d     = fc_shift;
					idx_d    = idx_q + 2'd1;
					if (full) begin
						hash_d  = fc_shift;
						phase_d = PH_PARAM_LEN;
					end
				end
				PH_PARAM_LEN: begin
					res.role = ROLE_HEADER;
					fc_d     = fc_shift;
					idx_d    = idx_q + 2'd1;
					if (full) begin
						if (fc_shift > {{(COLLECT_W-PARAM_LEN_W){1'b0}}, cfg.max_param_len}) begin
							res.error_now = 1'b1;
							stopped_d     = 1'b1;
						end else begin
							param_len_d = fc_shift[PARAM_LEN_W-1:0];
							rem_d       = fc_shift[PARAM_LEN_W-1:0];
							if (fc_shift[PARAM_LEN_W-1:0] == '0) begin
								res.frame_done = 1'b1;
							end else begin
								phase_d = PH_PARAM;
							end
						end
					end
				end
				PH_PARAM: begin
					res.role = ROLE_PARAM;
					rem_d    = rem_dec;
					if (rem_dec == '0) begin
						res.frame_done = 1'b1;
					end
				end
				default: begin
					phase_d  = PH_NAME_LEN;
					res.role = ROLE_HEADER;
					fc_d     = fc_shift;
					idx_d    = idx_q + 2'd1;
					if (full) begin
						if (fc_shift > {{(COLLECT_W-NAME_LEN_W){1'b0}}, cfg.max_name_len}) begin
							res.error_now = 1'b1;
							stopped_d     = 1'b1;
						end else begin
							name_len_d = fc_shift[NAME_LEN_W-1:0];
							rem_d      = {{(PARAM_LEN_W-NAME_LEN_W){1'b0}},
								fc_shift[NAME_LEN_W-1:0]};
							phase_d    = (fc_shift[NAME_LEN_W-1:0] == '0) ? PH_HASH : PH_NAME;
						end
					end
				end
			endcase
		end
		res.name_len  = name_len_d;
		res.hash      = hash_d;
		res.param_len = param_len_d;
		res.halted    = stopped_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_NAME_LEN;
			idx_q       <= '0;
			fc_q        <= '0;
			name_len_q  <= '0;
			hash_q      <= '0;
			param_len_q <= '0;
			rem_q       <= '0;
			stopped_q   <= 1'b0;
		end else if (fire) begin
			stopped_q <= stopped_d;
			if (res.frame_done) begin
				phase_q     <= PH_NAME_LEN;
				idx_q       <= '0;
				fc_q        <= '0;
				name_len_q  <= '0;
				hash_q      <= '0;
				param_len_q <= '0;
				rem_q       <= '0;
			end else begin
				phase_q     <= phase_d;
				idx_q       <= idx_d;
				fc_q        <= fc_d;
				name_len_q  <= name_len_d;
				hash_q      <= hash_d;
				param_len_q <= param_len_d;
				rem_q       <= rem_d;
			end
		end
	end

`include "command_frame_deframer_assert.svh"

	`CFD_ASSERT(a_stop_sticky, stopped_q |=> stopped_q, "halt flag cleared without reset")
	`CFD_ASSERT(a_halted_ignored, fire && stopped_q |-> res.role == ROLE_IGNORED, "byte parsed while halted")
	`CFD_NEVER(a_done_and_halt, fire && res.frame_done && res.halted, "frame completed on a halting byte")
	`CFD_ASSERT(a_body_count, (phase_q == PH_NAME || phase_q == PH_PARAM) |-> rem_q != '0, "body phase with no bytes left")

endmodule

// ===== src/command_frame_deframer.sv =====
// Top level of the command frame deframer: input register, parser and result register.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     data_byte, link_closed
//   out      output     out_valid / out_stall   byte_role .. halted
//   cfg      input      cfg_we                  cfg_index, cfg_data
//
// One byte is accepted per cycle while in_stall is low; its result passes through the input
// register and the result register, and an output stall can hold it between them. The
// parser is one combinational pass between the two registers. Reset clears the parse
// state and loads the length limits with 128 and 8192. A stalled result is held while
// one more item waits in the input register, after which in_stall is raised.
module command_frame_deframer
	import cfd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [BYTE_W-1:0]      data_byte,
	input  logic                   link_closed,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [ROLE_W-1:0]      byte_role,
	output logic [BYTE_W-1:0]      byte_value,
	output logic [NAME_LEN_W-1:0]  name_length,
	output logic [COLLECT_W-1:0]   command_hash,
	output logic [PARAM_LEN_W-1:0] param_length,
	output logic                   frame_done,
	output logic                   error_now,
	output logic                   halted,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfd_cfg_t          cfg_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              closed_s1;
	logic              valid_s2;
	cfd_result_t       res_s2;
	cfd_result_t       res;
	logic              out_ready;
	logic              fire;
	logic              in_accept;

	assign out_ready = !valid_s2 || !out_stall;
	assign fire      = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_name_len  <= MAX_NAME_LEN_RST;
			cfg_q.max_param_len <= MAX_PARAM_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_NAME_LEN:  cfg_q.max_name_len  <= cfg_data[NAME_LEN_W-1:0];
				REG_MAX_PARAM_LEN: cfg_q.max_param_len <= cfg_data[PARAM_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1   <= data_byte;
			closed_s1 <= link_closed;
		end
	end

	cfd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.data_byte   (byte_s1),
		.link_closed (closed_s1),
		.cfg         (cfg_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign byte_role    = res_s2.role;
	assign byte_value   = res_s2.value;
	assign name_length  = res_s2.name_len;
	assign command_hash = res_s2.hash;
	assign param_length = res_s2.param_len;
	assign frame_done   = res_s2.frame_done;
	assign error_now    = res_s2.error_now;
	assign halted       = res_s2.halted;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the command frame deframer with a built-in frame parser predictor.
module tb;
	import cfd_pkg::*;

	localparam int unsigned QUIET_LIMIT = 2000;

	typedef enum logic [2:0] {
		PH_NAME_LEN,
		PH_NAME,
		PH_HASH,
		PH_PARAM_LEN,
		PH_PARAM
	} parse_phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              closed;
	} stream_item_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [BYTE_W-1:0]      data_byte = '0;
	logic                   link_closed = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [ROLE_W-1:0]      byte_role;
	logic [BYTE_W-1:0]      byte_value;
	logic [NAME_LEN_W-1:0]  name_length;
	logic [COLLECT_W-1:0]   command_hash;
	logic [PARAM_LEN_W-1:0] param_length;
	logic                   frame_done;
	logic                   error_now;
	logic                   halted;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	command_frame_deframer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.link_closed  (link_closed),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.byte_role    (byte_role),
		.byte_value   (byte_value),
		.name_length  (name_length),
		.command_hash (command_hash),
		.param_length (param_length),
		.frame_done   (frame_done),
		.error_now    (error_now),
		.halted       (halted),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Predictor state and its copy of the limit registers.
	parse_phase_t           ph;
	logic [1:0]             hdr_idx;
	logic [31:0]            shift_word;
	logic [NAME_LEN_W-1:0]  cur_name_len;
	logic [31:0]            cur_hash;
	logic [PARAM_LEN_W-1:0] cur_param_len;
	logic [PARAM_LEN_W-1:0] bytes_left;
	logic                   stopped_m;
	logic [NAME_LEN_W-1:0]  lim_name;
	logic [PARAM_LEN_W-1:0] lim_param;

	stream_item_t pending[$];
	cfd_result_t  expected_results[$];

	bit          idle_on;
	int unsigned gap_left;
	int unsigned stall_left;
	int unsigned quiet_cycles;
	int unsigned mismatches;
	int unsigned results_checked;
	int unsigned frames_total;
	int unsigned name_bytes;
	int unsigned param_bytes;
	int unsigned ignored_bytes;
	int unsigned length_errors;
	cfd_result_t  want;
	cfd_result_t  got;
	stream_item_t nxt;
	string        ending;

	function automatic void clear_frame();
		cur_name_len = '0;
		cur_hash = '0;
		cur_param_len = '0;
		bytes_left = '0;
		hdr_idx = '0;
		shift_word = '0;
		ph = PH_NAME_LEN;
	endfunction

	function automatic logic shift_in(input logic [7:0] b);
		logic full;
		shift_word = {b, shift_word[31:8]};
		full = (hdr_idx == 2'd3);
		hdr_idx = hdr_idx + 2'd1;
		return full;
	endfunction

	function automatic cfd_result_t deframe_byte(input logic [7:0] b, input logic closed);
		cfd_result_t r;
		r.role = ROLE_IGNORED;
		r.value = closed ? 8'h00 : b;
		r.frame_done = 1'b0;
		r.error_now = 1'b0;
		if (closed) begin
			stopped_m = 1'b1;
		end else if (!stopped_m) begin
			case (ph)
				PH_NAME: begin
					r.role = ROLE_NAME;
					bytes_left = bytes_left - 1'b1;
					if (bytes_left == 0) ph = PH_HASH;
				end
				PH_HASH: begin
					r.role = ROLE_HEADER;
					if (shift_in(b)) begin
						cur_hash = shift_word;
						ph = PH_PARAM_LEN;
					end
				end
				PH_PARAM_LEN: begin
					r.role = ROLE_HEADER;
					if (shift_in(b)) begin
						if (shift_word > {18'b0, lim_param}) begin
							r.error_now = 1'b1;
							stopped_m = 1'b1;
						end else begin
							cur_param_len = shift_word[PARAM_LEN_W-1:0];
							bytes_left = cur_param_len;
							if (cur_param_len == 0) r.frame_done = 1'b1;
							else ph = PH_PARAM;
						end
					end
				end
				PH_PARAM: begin
					r.role = ROLE_PARAM;
					bytes_left = bytes_left - 1'b1;
					if (bytes_left == 0) r.frame_done = 1'b1;
				end
				default: begin
					ph = PH_NAME_LEN;
					r.role = ROLE_HEADER;
					if (shift_in(b)) begin
						if (shift_word > {24'b0, lim_name}) begin
							r.error_now = 1'b1;
							stopped_m = 1'b1;
						end else begin
							cur_name_len = shift_word[NAME_LEN_W-1:0];
							bytes_left = PARAM_LEN_W'(cur_name_len);
							ph = (cur_name_len == 0) ? PH_HASH : PH_NAME;
						end
					end
				end
			endcase
		end
		r.name_len = cur_name_len;
		r.hash = cur_hash;
		r.param_len = cur_param_len;
		r.halted = stopped_m;
		if (r.frame_done) clear_frame();
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] actual,
			input logic [31:0] wanted);
		mismatches++;
		$display("MISMATCH at result %0d, %s: got %0h, expected %0h",
			results_checked, what, actual, wanted);
	endtask

	task automatic check_field(input string what, input logic [31:0] actual,
			input logic [31:0] wanted);
		if (actual !== wanted) report_mismatch(what, actual, wanted);
	endtask

	// Input side: one item is presented at a time and held while stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= '0;
			link_closed <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				want = deframe_byte(data_byte, link_closed);
				expected_results.insert(expected_results.size(), want);
				if (want.frame_done) frames_total++;
				if (want.error_now) length_errors++;
				case (want.role)
					ROLE_NAME: name_bytes++;
					ROLE_PARAM: param_bytes++;
					ROLE_IGNORED: ignored_bytes++;
					default: ;
				endcase
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending.size() == 0) begin
					in_valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 15) == 0) begin
					gap_left = $urandom_range(0, 17);
					in_valid <= 1'b0;
				end else begin
					nxt = pending.pop_front();
					in_valid <= 1'b1;
					data_byte <= nxt.data;
					link_closed <= nxt.closed;
				end
			end
		end
	end

	// Output side: random stall bursts and the field-by-field comparison.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_checked++;
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected", 32'h0, 32'h0);
				end else begin
					got = expected_results.pop_front();
					check_field("byte_role", byte_role, got.role);
					check_field("byte_value", byte_value, got.value);
					check_field("name_length", name_length, got.name_len);
					check_field("command_hash", command_hash, got.hash);
					check_field("param_length", param_length, got.param_len);
					check_field("frame_done", frame_done, got.frame_done);
					check_field("error_now", error_now, got.error_now);
					check_field("halted", halted, got.halted);
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 15) == 0) begin
				stall_left = $urandom_range(0, 17);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
				$display("tb failed");
				$finish;
			end
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic closed);
		stream_item_t it;
		it.data = b;
		it.closed = closed;
		pending.insert(pending.size(), it);
	endtask

	task automatic queue_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++) queue_byte(w[8*i +: 8], 1'b0);
	endtask

	task automatic queue_frame(input int unsigned nlen, input int unsigned plen);
		queue_word(nlen);
		repeat (nlen) queue_byte($urandom_range(0, 255), 1'b0);
		queue_word($urandom());
		queue_word(plen);
		repeat (plen) queue_byte($urandom_range(0, 255), 1'b0);
	endtask

	function automatic int unsigned pick_len(input int unsigned lim, input int unsigned cap);
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r == 0 || lim == 0) return 0;
		if (r == 1) return (lim <= 300) ? lim : $urandom_range(0, cap);
		return $urandom_range(0, (lim < cap) ? lim : cap);
	endfunction

	// The check runs at the falling edge so that every rising-edge update has settled.
	task automatic wait_idle();
		do @(negedge clk);
		while (pending.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		if (idx == REG_MAX_NAME_LEN) lim_name = NAME_LEN_W'(value);
		else lim_param = PARAM_LEN_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_frames(input int unsigned count);
		repeat (count) queue_frame(pick_len(lim_name, 6), pick_len(lim_param, 12));
		wait_idle();
	endtask

	// Ends the parse for good: a name length over its limit, a parameter length over
	// its limit, or a link close inside a frame; then ignored noise follows.
	task automatic queue_halt_ending(output string how);
		int unsigned kind;
		int unsigned nlen;
		logic [31:0] bad;
		kind = $urandom_range(0, 2);
		if (kind == 0) begin
			bad = $urandom_range(0, 1) ? 32'(lim_name) + 1 : ($urandom() | 32'h8000_0000);
			queue_word(bad);
			how = "name length over limit";
		end else if (kind == 1) begin
			nlen = pick_len(lim_name, 4);
			queue_word(nlen);
			repeat (nlen) queue_byte($urandom_range(0, 255), 1'b0);
			queue_word($urandom());
			bad = $urandom_range(0, 1) ? 32'(lim_param) + 1 : ($urandom() | 32'h8000_0000);
			queue_word(bad);
			how = "parameter length over limit";
		end else begin
			queue_word(0);
			repeat ($urandom_range(1, 4)) queue_byte($urandom_range(0, 255), 1'b0);
			queue_byte($urandom_range(1, 255), 1'b1);
			how = "link closed inside a frame";
		end
		repeat (20) queue_byte($urandom_range(0, 255), $urandom_range(0, 3) == 0);
		queue_byte($urandom_range(1, 255), 1'b1);
		queue_byte(8'hFF, 1'b0);
	endtask

	initial begin
		lim_name = MAX_NAME_LEN_RST;
		lim_param = MAX_PARAM_LEN_RST;
		stopped_m = 1'b0;
		clear_frame();
		idle_on = 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Empty name with empty parameters, then one-byte name and parameter blocks.
		queue_word(32'h0);
		queue_word(32'hFFFF_FFFF);
		queue_word(32'h0);
		queue_word(32'h1);
		queue_byte(8'h00, 1'b0);
		queue_word(32'h0);
		queue_word(32'h1);
		queue_byte(8'hFF, 1'b0);
		run_frames(5);

		write_reg(REG_MAX_NAME_LEN, 255);
		write_reg(REG_MAX_PARAM_LEN, 0);
		run_frames(5);

		write_reg(REG_MAX_NAME_LEN, 0);
		write_reg(REG_MAX_PARAM_LEN, 8192);
		queue_frame(0, 64);
		run_frames(4);

		idle_on = 1'b0;
		write_reg(REG_MAX_NAME_LEN, $urandom_range(1, 254));
		write_reg(REG_MAX_PARAM_LEN, $urandom_range(1, 300));
		run_frames(5);

		idle_on = 1'b1;
		write_reg(REG_MAX_NAME_LEN, $urandom_range(1, 254));
		write_reg(REG_MAX_PARAM_LEN, $urandom_range(1, 300));
		run_frames(5);

		idle_on = 1'b0;
		write_reg(REG_MAX_NAME_LEN, $urandom_range(0, 255));
		write_reg(REG_MAX_PARAM_LEN, $urandom_range(0, 8192));
		repeat (4) queue_frame(pick_len(lim_name, 6), pick_len(lim_param, 12));
		queue_halt_ending(ending);
		wait_idle();
		repeat (8) @(posedge clk);

		$display("Checked %0d results: %0d frames, %0d name and %0d parameter bytes.",
			results_checked, frames_total, name_bytes, param_bytes);
		$display("Limits swept from 0 to their maximum; stream halted by %s (%0d ignored).",
			ending, ignored_bytes);
		if (mismatches == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/cfd_pkg.sv
src/cfd_parser.sv
src/command_frame_deframer.sv
tb/sv/tb.sv
